FILE: sv/swse_pkg.sv
// ----------------------------------------------------------------------------
// swse_pkg
// Shared types and constants for the spotlight wedge scanline edge block.
// ----------------------------------------------------------------------------
`default_nettype none

package swse_pkg;

  localparam int LINES   = 192;
  localparam int PIXELS  = 256;

  localparam int LINE_W  = 8;
  localparam int EDGE_W  = 8;
  localparam int APEX_W  = 10;
  localparam int COT_W   = 16;
  localparam int SIGN_W  = 2;
  localparam int DY_W    = APEX_W + 1;
  localparam int PROD_W  = DY_W + COT_W;
  localparam int SUM_W   = PROD_W + 1;
  localparam int IDX_W   = 3;
  localparam int DATA_W  = 16;

  localparam logic [IDX_W-1:0] REG_APEX_X     = 3'd0;
  localparam logic [IDX_W-1:0] REG_APEX_Y     = 3'd1;
  localparam logic [IDX_W-1:0] REG_LEFT_COT   = 3'd2;
  localparam logic [IDX_W-1:0] REG_RIGHT_COT  = 3'd3;
  localparam logic [IDX_W-1:0] REG_LEFT_SIGN  = 3'd4;
  localparam logic [IDX_W-1:0] REG_RIGHT_SIGN = 3'd5;

  localparam logic [SIGN_W-1:0] SIGN_NEG  = 2'd0;
  localparam logic [SIGN_W-1:0] SIGN_ZERO = 2'd1;
  localparam logic [SIGN_W-1:0] SIGN_POS  = 2'd2;

  localparam logic signed [APEX_W-1:0] RST_APEX_X = 10'sd128;
  localparam logic signed [APEX_W-1:0] RST_APEX_Y = 10'sd96;
  localparam logic signed [COT_W-1:0]  RST_LEFT_COT  = 16'sd171;
  localparam logic signed [COT_W-1:0]  RST_RIGHT_COT = 16'sd383;

  localparam logic [EDGE_W-1:0] EDGE_MAX = EDGE_W'(PIXELS - 1);
  localparam logic [LINE_W-1:0] LINE_MAX = LINE_W'(LINES - 1);

  typedef struct packed {
    logic              valid;
    logic [LINE_W-1:0] line;
    logic              left_zero;
    logic              right_full;
  } ctl_t;

  // clamp a signed row position to 0..LINES-1
  function automatic logic [LINE_W-1:0] clamp_line(input logic signed [APEX_W-1:0] v);
    logic [LINE_W-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > APEX_W'(LINES - 1)) begin
      r = LINE_MAX;
    end else begin
      r = v[LINE_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: sv/swse_edge.sv
// ----------------------------------------------------------------------------
// swse_edge
// One edge lane: registered dy * cot product, then apex add, truncation
// toward zero and clamp to the screen width.
// ----------------------------------------------------------------------------
`default_nettype none

module swse_edge (
  input  wire logic                                 clk,
  input  wire logic signed [swse_pkg::DY_W-1:0]     dy,
  input  wire logic signed [swse_pkg::COT_W-1:0]    cot,
  input  wire logic signed [swse_pkg::APEX_W-1:0]   apex_x,
  output logic             [swse_pkg::EDGE_W-1:0]   edge_px
);

  logic signed [swse_pkg::PROD_W-1:0] prod;
  logic        [swse_pkg::SUM_W-1:0]  sum;
  logic        [swse_pkg::SUM_W-10:0] whole;

  always_ff @(posedge clk) begin
    prod <= dy * cot;
  end

  assign sum = {{(swse_pkg::SUM_W-swse_pkg::APEX_W-8){apex_x[swse_pkg::APEX_W-1]}},
                apex_x, 8'b0} + {prod[swse_pkg::PROD_W-1], prod};
  assign whole = sum[swse_pkg::SUM_W-2:8];

  // negative sums truncate toward zero and clamp to zero
  always_comb begin
    if (sum[swse_pkg::SUM_W-1]) begin
      edge_px = '0;
    end else if (whole > (swse_pkg::SUM_W-9)'(swse_pkg::PIXELS - 1)) begin
      edge_px = swse_pkg::EDGE_MAX;
    end else begin
      edge_px = whole[swse_pkg::EDGE_W-1:0];
    end
  end

endmodule

`default_nettype wire

FILE: sv/spotlight_wedge_scanline_edges.sv
// ----------------------------------------------------------------------------
// spotlight_wedge_scanline_edges
// Per-scanline left and right window edges of a light wedge.
// ----------------------------------------------------------------------------
// A scanline is taken on every clock with start high (busy is never raised).
// Its edge pair appears on line_out, left_edge and right_edge for one cycle
// with done high; lines outside the wedge band give no done pulse. The path
// runs through the input register, the registered cotangent multiply and
// the result register. The receiver cannot stall, so results must be
// captured on the done cycle. Registers are written through cfg_valid/
// cfg_ready, which is always ready; the user must write them only while no
// line is in flight, which the block itself does not enforce.
// ----------------------------------------------------------------------------
`default_nettype none

module spotlight_wedge_scanline_edges (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [swse_pkg::LINE_W-1:0]       line_index,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [swse_pkg::IDX_W-1:0]        cfg_index,
  input  wire logic [swse_pkg::DATA_W-1:0]       cfg_data,
  output logic                                   done,
  output logic [swse_pkg::LINE_W-1:0]            line_out,
  output logic [swse_pkg::EDGE_W-1:0]            left_edge,
  output logic [swse_pkg::EDGE_W-1:0]            right_edge
);

  logic signed [swse_pkg::APEX_W-1:0] apex_x;
  logic signed [swse_pkg::APEX_W-1:0] apex_y;
  logic signed [swse_pkg::COT_W-1:0]  left_cot;
  logic signed [swse_pkg::COT_W-1:0]  right_cot;
  logic        [swse_pkg::SIGN_W-1:0] left_sign;
  logic        [swse_pkg::SIGN_W-1:0] right_sign;

  logic                               in_valid;
  logic        [swse_pkg::LINE_W-1:0] in_line;

  swse_pkg::ctl_t                     ctl_next;
  swse_pkg::ctl_t                     ctl;

  logic lpos, lneg, rpos, rneg;
  logic [swse_pkg::LINE_W-1:0]        band_top;
  logic [swse_pkg::LINE_W-1:0]        band_bot;
  logic signed [swse_pkg::DY_W-1:0]   dy;
  logic                               dy_pos;
  logic signed [swse_pkg::COT_W-1:0]  lsel_cot;
  logic signed [swse_pkg::COT_W-1:0]  rsel_cot;
  logic [swse_pkg::EDGE_W-1:0]        left_px;
  logic [swse_pkg::EDGE_W-1:0]        right_px;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      apex_x     <= swse_pkg::RST_APEX_X;
      apex_y     <= swse_pkg::RST_APEX_Y;
      left_cot   <= swse_pkg::RST_LEFT_COT;
      right_cot  <= swse_pkg::RST_RIGHT_COT;
      left_sign  <= swse_pkg::SIGN_POS;
      right_sign <= swse_pkg::SIGN_POS;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        swse_pkg::REG_APEX_X:     apex_x     <= cfg_data[swse_pkg::APEX_W-1:0];
        swse_pkg::REG_APEX_Y:     apex_y     <= cfg_data[swse_pkg::APEX_W-1:0];
        swse_pkg::REG_LEFT_COT:   left_cot   <= cfg_data;
        swse_pkg::REG_RIGHT_COT:  right_cot  <= cfg_data;
        swse_pkg::REG_LEFT_SIGN:  left_sign  <= cfg_data[swse_pkg::SIGN_W-1:0];
        swse_pkg::REG_RIGHT_SIGN: right_sign <= cfg_data[swse_pkg::SIGN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    in_line <= line_index;
  end

  // band and quadrant decode
  assign lpos = left_sign[1];
  assign rpos = right_sign[1];
  assign lneg = (left_sign == swse_pkg::SIGN_NEG);
  assign rneg = (right_sign == swse_pkg::SIGN_NEG);

  always_comb begin
    band_top = '0;
    band_bot = swse_pkg::LINE_MAX;
    if (!lneg && !rneg) begin
      band_bot = swse_pkg::clamp_line(apex_y);
    end else if (!lpos && !rpos) begin
      band_top = swse_pkg::clamp_line(apex_y);
    end
  end

  assign dy     = {apex_y[swse_pkg::APEX_W-1], apex_y} -
                  {{(swse_pkg::DY_W-swse_pkg::LINE_W){1'b0}}, in_line};
  assign dy_pos = !dy[swse_pkg::DY_W-1] && (dy != '0);

  always_comb begin
    ctl_next.valid      = in_valid && (in_line >= band_top) && (in_line < band_bot);
    ctl_next.line       = in_line;
    ctl_next.left_zero  = 1'b0;
    ctl_next.right_full = 1'b0;
    if (lpos && rpos) begin
      lsel_cot = left_cot;
      rsel_cot = right_cot;
    end else if (lneg && rneg) begin
      lsel_cot = right_cot;
      rsel_cot = left_cot;
    end else if (lpos && rneg) begin
      lsel_cot = dy_pos ? left_cot : right_cot;
      rsel_cot = right_cot;
      ctl_next.right_full = 1'b1;
    end else begin
      lsel_cot = left_cot;
      rsel_cot = dy_pos ? right_cot : left_cot;
      ctl_next.left_zero = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.valid <= 1'b0;
    end else begin
      ctl <= ctl_next;
    end
  end

  swse_edge u_left (
    .clk     (clk),
    .dy      (dy),
    .cot     (lsel_cot),
    .apex_x  (apex_x),
    .edge_px (left_px)
  );

  swse_edge u_right (
    .clk     (clk),
    .dy      (dy),
    .cot     (rsel_cot),
    .apex_x  (apex_x),
    .edge_px (right_px)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    line_out   <= ctl.line;
    left_edge  <= ctl.left_zero ? '0 : left_px;
    right_edge <= ctl.right_full ? swse_pkg::EDGE_MAX : right_px;
  end

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the spotlight wedge scanline edge block. Scanlines are sent
// through the start/busy port with random gaps, the register file is set
// through the write channel between phases, and every done pulse is checked
// field by field against a scanline window predictor kept in this module.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [swse_pkg::IDX_W-1:0]  REG_SPARE_A  = 3'd6;
  localparam logic [swse_pkg::IDX_W-1:0]  REG_SPARE_B  = 3'd7;
  localparam logic [swse_pkg::SIGN_W-1:0] SIGN_POS_ALT = 2'd3;
  localparam logic [swse_pkg::APEX_W-1:0] APEX_MIN     = 10'h200;
  localparam logic [swse_pkg::APEX_W-1:0] APEX_MAX     = 10'h1FF;
  localparam logic [swse_pkg::COT_W-1:0]  COT_MIN      = 16'h8000;
  localparam logic [swse_pkg::COT_W-1:0]  COT_MAX      = 16'h7FFF;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int PHASES        = 12;
  localparam int PHASE_LINES   = 155;

  typedef struct packed {
    logic [swse_pkg::LINE_W-1:0] line;
    logic [swse_pkg::EDGE_W-1:0] left;
    logic [swse_pkg::EDGE_W-1:0] right;
  } window_pair_t;

  logic                          clk;
  logic                          rst;
  logic                          start;
  logic                          busy;
  logic [swse_pkg::LINE_W-1:0]   line_index;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [swse_pkg::IDX_W-1:0]    cfg_index;
  logic [swse_pkg::DATA_W-1:0]   cfg_data;
  logic                          done;
  logic [swse_pkg::LINE_W-1:0]   line_out;
  logic [swse_pkg::EDGE_W-1:0]   left_edge;
  logic [swse_pkg::EDGE_W-1:0]   right_edge;

  logic signed [swse_pkg::APEX_W-1:0] cur_apex_x;
  logic signed [swse_pkg::APEX_W-1:0] cur_apex_y;
  logic signed [swse_pkg::COT_W-1:0]  cur_left_cot;
  logic signed [swse_pkg::COT_W-1:0]  cur_right_cot;
  logic [swse_pkg::SIGN_W-1:0]        cur_left_sign;
  logic [swse_pkg::SIGN_W-1:0]        cur_right_sign;

  window_pair_t expected_pairs[$];
  window_pair_t seen_want;
  int           errors;
  int           cycle_count;

  spotlight_wedge_scanline_edges uut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .line_index (line_index),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .done       (done),
    .line_out   (line_out),
    .left_edge  (left_edge),
    .right_edge (right_edge)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // q8.8 sum truncated toward zero, clamped to the screen
  function automatic logic [swse_pkg::EDGE_W-1:0] window_pixel(input int ax, input int dy,
                                                               input int cot);
    int sum;
    int whole;
    sum = ax * 256 + dy * cot;
    if (sum >= 0) begin
      whole = sum >>> 8;
    end else begin
      whole = -((-sum) >>> 8);
    end
    if (whole < 0) begin
      whole = 0;
    end else if (whole > swse_pkg::PIXELS - 1) begin
      whole = swse_pkg::PIXELS - 1;
    end
    return swse_pkg::EDGE_W'(whole);
  endfunction

  function automatic bit predict_window(input logic [swse_pkg::LINE_W-1:0] ln,
                                        output window_pair_t pair);
    int  ax;
    int  ay;
    int  lc;
    int  rc;
    int  line_n;
    int  top;
    int  bottom;
    int  dy;
    bit  lpos;
    bit  lneg;
    bit  rpos;
    bit  rneg;
    ax = cur_apex_x;
    ay = cur_apex_y;
    lc = cur_left_cot;
    rc = cur_right_cot;
    line_n = int'(ln);
    lpos = cur_left_sign >= swse_pkg::SIGN_POS;
    lneg = cur_left_sign == swse_pkg::SIGN_NEG;
    rpos = cur_right_sign >= swse_pkg::SIGN_POS;
    rneg = cur_right_sign == swse_pkg::SIGN_NEG;
    top = 0;
    bottom = swse_pkg::LINES - 1;
    pair = '0;
    if (!lneg && !rneg) begin
      bottom = ay;
    end else if (!lpos && !rpos) begin
      top = ay;
    end
    if (top < 0) top = 0;
    if (top > swse_pkg::LINES - 1) top = swse_pkg::LINES - 1;
    if (bottom < 0) bottom = 0;
    if (bottom > swse_pkg::LINES - 1) bottom = swse_pkg::LINES - 1;
    if (line_n < top || line_n >= bottom) begin
      return 1'b0;
    end
    dy = ay - line_n;
    pair.line = ln;
    if (lpos && rpos) begin
      pair.left  = window_pixel(ax, dy, lc);
      pair.right = window_pixel(ax, dy, rc);
    end else if (lneg && rneg) begin
      pair.left  = window_pixel(ax, dy, rc);
      pair.right = window_pixel(ax, dy, lc);
    end else if (lpos && rneg) begin
      pair.left  = window_pixel(ax, dy, (dy > 0) ? lc : rc);
      pair.right = swse_pkg::EDGE_MAX;
    end else begin
      pair.right = window_pixel(ax, dy, (dy > 0) ? rc : lc);
      pair.left  = '0;
    end
    return 1'b1;
  endfunction

  function automatic void apply_reg(input logic [swse_pkg::IDX_W-1:0] idx,
                                    input logic [swse_pkg::DATA_W-1:0] data);
    case (idx)
      swse_pkg::REG_APEX_X:     cur_apex_x     = data[swse_pkg::APEX_W-1:0];
      swse_pkg::REG_APEX_Y:     cur_apex_y     = data[swse_pkg::APEX_W-1:0];
      swse_pkg::REG_LEFT_COT:   cur_left_cot   = data[swse_pkg::COT_W-1:0];
      swse_pkg::REG_RIGHT_COT:  cur_right_cot  = data[swse_pkg::COT_W-1:0];
      swse_pkg::REG_LEFT_SIGN:  cur_left_sign  = data[swse_pkg::SIGN_W-1:0];
      swse_pkg::REG_RIGHT_SIGN: cur_right_sign = data[swse_pkg::SIGN_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic int idle_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [swse_pkg::APEX_W-1:0] pick_apex(input int hi);
    case ($urandom_range(0, 9))
      0:       return APEX_MIN;
      1:       return APEX_MAX;
      2:       return swse_pkg::APEX_W'($urandom);
      default: return swse_pkg::APEX_W'($urandom_range(0, hi));
    endcase
  endfunction

  function automatic logic [swse_pkg::COT_W-1:0] pick_cot();
    case ($urandom_range(0, 9))
      0:       return COT_MIN;
      1:       return COT_MAX;
      2, 3:    return swse_pkg::COT_W'($urandom);
      default: return swse_pkg::COT_W'(int'($urandom_range(0, 1200)) - 600);
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  task automatic write_reg(input logic [swse_pkg::IDX_W-1:0] idx,
                           input logic [swse_pkg::DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    apply_reg(idx, data);
    @(posedge clk);
  endtask

  task automatic send_line(input logic [swse_pkg::LINE_W-1:0] ln, input bit no_gaps);
    window_pair_t pair;
    int           gap;
    start      <= 1'b1;
    line_index <= ln;
    do @(posedge clk); while (busy);
    if (predict_window(ln, pair)) begin
      expected_pairs.push_back(pair);
    end
    gap = no_gaps ? 0 : idle_cycles();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (expected_pairs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_signs(input logic [swse_pkg::SIGN_W-1:0] ls,
                           input logic [swse_pkg::SIGN_W-1:0] rs);
    write_reg(swse_pkg::REG_LEFT_SIGN, swse_pkg::DATA_W'(ls));
    write_reg(swse_pkg::REG_RIGHT_SIGN, swse_pkg::DATA_W'(rs));
  endtask

  task automatic test_reset_values();
    send_line(8'd0, 1'b0);
    send_line(8'd96, 1'b0);
    send_line(8'd191, 1'b0);
    send_line(8'd255, 1'b0);
    drain_results();
  endtask

  task automatic test_sign_cases();
    logic [swse_pkg::SIGN_W-1:0] ls[5];
    logic [swse_pkg::SIGN_W-1:0] rs[5];
    ls = '{swse_pkg::SIGN_NEG, swse_pkg::SIGN_POS, swse_pkg::SIGN_NEG,
           swse_pkg::SIGN_ZERO, SIGN_POS_ALT};
    rs = '{swse_pkg::SIGN_NEG, swse_pkg::SIGN_NEG, swse_pkg::SIGN_POS,
           swse_pkg::SIGN_ZERO, swse_pkg::SIGN_NEG};
    write_reg(swse_pkg::REG_APEX_X, swse_pkg::DATA_W'(128));
    write_reg(swse_pkg::REG_APEX_Y, swse_pkg::DATA_W'(100));
    write_reg(swse_pkg::REG_LEFT_COT, swse_pkg::DATA_W'(-200));
    write_reg(swse_pkg::REG_RIGHT_COT, swse_pkg::DATA_W'(300));
    for (int c = 0; c < 5; c++) begin
      set_signs(ls[c], rs[c]);
      send_line(8'd40, 1'b0);
      send_line(8'd100, 1'b0);
      send_line(8'd160, 1'b0);
      drain_results();
    end
  endtask

  task automatic test_extremes();
    write_reg(swse_pkg::REG_APEX_X, swse_pkg::DATA_W'(APEX_MIN));
    write_reg(swse_pkg::REG_APEX_Y, swse_pkg::DATA_W'(APEX_MAX));
    write_reg(swse_pkg::REG_LEFT_COT, COT_MIN);
    write_reg(swse_pkg::REG_RIGHT_COT, COT_MAX);
    set_signs(swse_pkg::SIGN_POS, swse_pkg::SIGN_POS);
    send_line(8'd0, 1'b1);
    send_line(8'd190, 1'b1);
    drain_results();
    write_reg(swse_pkg::REG_APEX_X, swse_pkg::DATA_W'(APEX_MAX));
    write_reg(swse_pkg::REG_APEX_Y, swse_pkg::DATA_W'(APEX_MIN));
    set_signs(swse_pkg::SIGN_NEG, swse_pkg::SIGN_NEG);
    send_line(8'd0, 1'b1);
    send_line(8'd191, 1'b1);
    drain_results();
  endtask

  // spare indexes are dropped, upper data bits are masked off
  task automatic test_register_writes();
    write_reg(swse_pkg::REG_APEX_X, 16'hFC40);
    write_reg(swse_pkg::REG_APEX_Y, 16'hFC50);
    write_reg(swse_pkg::REG_LEFT_SIGN, 16'hFFFE);
    write_reg(swse_pkg::REG_RIGHT_SIGN, 16'hFFFE);
    write_reg(REG_SPARE_A, 16'hFFFF);
    write_reg(REG_SPARE_B, 16'h0000);
    send_line(8'd10, 1'b0);
    send_line(8'd79, 1'b0);
    drain_results();
  endtask

  task automatic set_random_config();
    write_reg(swse_pkg::REG_APEX_X, {6'($urandom), pick_apex(255)});
    write_reg(swse_pkg::REG_APEX_Y, {6'($urandom), pick_apex(200)});
    write_reg(swse_pkg::REG_LEFT_COT, pick_cot());
    write_reg(swse_pkg::REG_RIGHT_COT, pick_cot());
    write_reg(swse_pkg::REG_LEFT_SIGN,
              {14'($urandom), swse_pkg::SIGN_W'($urandom_range(0, 3))});
    write_reg(swse_pkg::REG_RIGHT_SIGN,
              {14'($urandom), swse_pkg::SIGN_W'($urandom_range(0, 3))});
    if ($urandom_range(0, 3) == 0) begin
      write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
                swse_pkg::DATA_W'($urandom));
    end
  endtask

  task automatic test_random_phases();
    bit                          no_gaps;
    logic [swse_pkg::LINE_W-1:0] ln;
    for (int p = 0; p < PHASES; p++) begin
      set_random_config();
      no_gaps = $urandom_range(0, 3) == 0;
      for (int i = 0; i < PHASE_LINES; i++) begin
        if ($urandom_range(0, 9) == 0) begin
          ln = swse_pkg::LINE_W'($urandom_range(swse_pkg::LINES, 255));
        end else begin
          ln = swse_pkg::LINE_W'($urandom_range(0, swse_pkg::LINES - 1));
        end
        send_line(ln, no_gaps);
        if ($urandom_range(0, 99) == 0) begin
          drain_results();
        end
      end
      drain_results();
    end
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_pairs.size() == 0) begin
        report_mismatch($sformatf("unexpected transaction line %0d", line_out));
      end else begin
        seen_want = expected_pairs.pop_front();
        if (line_out !== seen_want.line) begin
          report_mismatch($sformatf("line_out got %0d want %0d", line_out, seen_want.line));
        end
        if (left_edge !== seen_want.left) begin
          report_mismatch($sformatf("left_edge line %0d got %0d want %0d",
                                    seen_want.line, left_edge, seen_want.left));
        end
        if (right_edge !== seen_want.right) begin
          report_mismatch($sformatf("right_edge line %0d got %0d want %0d",
                                    seen_want.line, right_edge, seen_want.right));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    errors         = 0;
    cycle_count    = 0;
    cur_apex_x     = swse_pkg::RST_APEX_X;
    cur_apex_y     = swse_pkg::RST_APEX_Y;
    cur_left_cot   = swse_pkg::RST_LEFT_COT;
    cur_right_cot  = swse_pkg::RST_RIGHT_COT;
    cur_left_sign  = swse_pkg::SIGN_POS;
    cur_right_sign = swse_pkg::SIGN_POS;
    rst        <= 1'b1;
    start      <= 1'b0;
    line_index <= '0;
    cfg_valid  <= 1'b0;
    cfg_index  <= '0;
    cfg_data   <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_reset_values();
    test_sign_cases();
    test_extremes();
    test_register_writes();
    test_random_phases();
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: filelist.f
sv/swse_pkg.sv
sv/swse_edge.sv
sv/spotlight_wedge_scanline_edges.sv
tb/sv/tb_top.sv
